// ===== src/cam_pkg.sv =====
// Package for the cluster allocation map: opcodes, sequencer states and the
// scan accumulator and result types. No dependencies.
package cam_pkg;

    // Opcodes of an input item
    localparam logic [3:0] OP_FREE  = 4'd0;
    localparam logic [3:0] OP_USED  = 4'd1;
    localparam logic [3:0] OP_BAD   = 4'd2;
    localparam logic [3:0] OP_GOOD  = 4'd3;
    localparam logic [3:0] OP_FIRST = 4'd4;
    localparam logic [3:0] OP_RUN   = 4'd5;
    localparam logic [3:0] OP_STATS = 4'd6;
    localparam logic [3:0] OP_WRITE = 4'd7;
    localparam logic [3:0] OP_READ  = 4'd8;

    // Two-bit cluster codes
    localparam logic [1:0] CODE_FREE     = 2'd0;
    localparam logic [1:0] CODE_USED     = 2'd1;
    localparam logic [1:0] CODE_BAD_FREE = 2'd2;
    localparam logic [1:0] CODE_BAD_USED = 2'd3;

    localparam int POS_W   = 12;
    localparam int COUNT_W = 13;
    localparam int BASE_W  = POS_W - 2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_MODIFY,
        S_WRITE,
        S_SCAN,
        S_DONE
    } t_state;

    // Scan accumulator; the count fields wrap at their output widths
    typedef struct packed {
        logic               found;
        logic               run_done;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] len;
        logic [COUNT_W-1:0] cnt_free;
        logic [COUNT_W-1:0] cnt_used;
        logic [COUNT_W-1:0] cnt_bad_free;
        logic [COUNT_W-1:0] cnt_bad_used;
    } t_scan;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] run_length;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] bad_count;
        logic [COUNT_W-1:0] bad_free_count;
        logic [COUNT_W-1:0] bad_used_count;
        logic [7:0]         read_data;
    } t_result;

endpackage

// ===== src/cam_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on cam_pkg.
interface cam_item_if
    import cam_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [3:0]       opcode;
    logic [POS_W-1:0] cluster;
    logic [7:0]       map_byte;

    modport source (output valid, opcode, cluster, map_byte, input ready);
    modport sink   (input valid, opcode, cluster, map_byte, output ready);
endinterface

interface cam_result_if
    import cam_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] run_length;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] bad_count;
    logic [COUNT_W-1:0] bad_free_count;
    logic [COUNT_W-1:0] bad_used_count;
    logic [7:0]         read_data;

    modport source (output valid, found, position, run_length, free_count, used_count,
                    bad_count, bad_free_count, bad_used_count, read_data, input ready);
    modport sink   (input valid, found, position, run_length, free_count, used_count,
                    bad_count, bad_free_count, bad_used_count, read_data, output ready);
endinterface

// ===== src/cam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/cam_scan_unit.sv =====
// Shared scan unit: folds one map byte (four clusters) into the search and
// count accumulator. Depends on cam_pkg.
module cam_scan_unit
    import cam_pkg::*;
(
    input  logic [7:0]        i_byte,
    input  logic [BASE_W-1:0] i_base,
    input  t_scan             i_acc,
    output t_scan             o_acc
);
    always_comb begin
        t_scan      acc;
        logic [1:0] code;
        acc = i_acc;
        for (int k = 0; k < 4; k++) begin
            code = i_byte[2*k +: 2];
            // Track the first free run; stop at its first non-free cluster
            if (code == CODE_FREE) begin
                if (!acc.run_done) begin
                    if (!acc.found) begin
                        acc.found = 1'b1;
                        acc.pos   = {i_base, 2'(k)};
                    end
                    acc.len = acc.len + COUNT_W'(1);
                end
            end else if (acc.found) begin
                acc.run_done = 1'b1;
            end
            // Count each code
            case (code)
                CODE_FREE:     acc.cnt_free     = acc.cnt_free + COUNT_W'(1);
                CODE_USED:     acc.cnt_used     = acc.cnt_used + COUNT_W'(1);
                CODE_BAD_FREE: acc.cnt_bad_free = acc.cnt_bad_free + COUNT_W'(1);
                default:       acc.cnt_bad_used = acc.cnt_bad_used + COUNT_W'(1);
            endcase
        end
        o_acc = acc;
    end
endmodule

// ===== src/cluster_allocation_map.sv =====
// Cluster allocation map, four two-bit cluster codes per map byte in one RAM.
// Mark ops fetch and modify one byte; byte write/read touch one byte; find/run/stats scan
// min(cluster_count, MAX_CLUSTERS)/4 bytes. Only one item is in flight: ready only when idle.
// Reset: synchronous; then clears the map one byte per cycle, all MAX_CLUSTERS/4 bytes
// (1024 by default), with ready low; cluster_count resets to 4096.
module cluster_allocation_map
    import cam_pkg::*;
#(
    parameter int MAX_CLUSTERS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    cam_item_if.sink           i_item,
    cam_result_if.source       o_result
);
    localparam int MAP_BYTES = MAX_CLUSTERS / 4;
    localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CCW = ($clog2(MAX_CLUSTERS + 1) > COUNT_W) ?
                         $clog2(MAX_CLUSTERS + 1) : COUNT_W;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_cluster_count;
    logic [3:0]         r_op, n_op;
    logic [POS_W-1:0]   r_cluster, n_cluster;
    logic [7:0]         r_wbyte, n_wbyte;
    logic [AW:0]        r_scan_len, n_scan_len;
    logic [AW:0]        r_addr, n_addr;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_base, n_base;
    t_scan              r_scan, n_scan, scan_next;
    logic               r_out_valid, n_out_valid;
    t_result            r_res, n_res;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]         ram_wdata, ram_rdata;

    logic [CCW-1:0]     cc_ext, cc_lim;
    logic               mark_in_range, byte_in_range;
    logic [2:0]         bit_sel;
    logic [7:0]         bit_mask;

    cam_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cam_scan_unit u_scan (
        .i_byte (ram_rdata),
        .i_base (BASE_W'(r_base)),
        .i_acc  (r_scan),
        .o_acc  (scan_next)
    );

    // Clamp the scan range to whole bytes of the map
    assign cc_ext = CCW'(r_cluster_count);
    assign cc_lim = (cc_ext > CCW'(MAX_CLUSTERS)) ? CCW'(MAX_CLUSTERS) : cc_ext;

    assign mark_in_range = (32'(r_cluster[POS_W-1:2]) < MAP_BYTES);
    assign byte_in_range = (32'(r_cluster) < MAP_BYTES);
    assign bit_sel  = {r_cluster[1:0], 1'b0} + 3'((r_op == OP_BAD) || (r_op == OP_GOOD));
    assign bit_mask = 8'(1) << bit_sel;

    assign i_item.ready = (r_state == S_IDLE);

    // Sequencer: next state, RAM access, scan and result
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cluster   = r_cluster;
        n_wbyte     = r_wbyte;
        n_scan_len  = r_scan_len;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_base      = r_base;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !o_result.ready;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_addr[AW-1:0];
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_addr[AW-1:0];

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + (AW+1)'(1);
                if (r_addr == (AW+1)'(MAP_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    n_op       = i_item.opcode;
                    n_cluster  = i_item.cluster;
                    n_wbyte    = i_item.map_byte;
                    n_scan_len = (AW+1)'(cc_lim >> 2);
                    n_addr     = '0;
                    n_pend     = 1'b0;
                    n_scan     = '0;
                    case (i_item.opcode) inside
                        [OP_FREE:OP_GOOD], OP_READ: n_state = S_FETCH;
                        OP_FIRST, OP_RUN, OP_STATS: n_state = S_SCAN;
                        OP_WRITE:                   n_state = S_WRITE;
                        default:                    n_state = S_DONE;
                    endcase
                end
            end
            S_FETCH: begin
                // Read the addressed byte; drop out-of-range accesses
                if (r_op == OP_READ) begin
                    ram_re    = byte_in_range;
                    ram_raddr = AW'(r_cluster);
                    n_state   = S_DONE;
                end else begin
                    ram_re    = mark_in_range;
                    ram_raddr = AW'(r_cluster[POS_W-1:2]);
                    n_state   = mark_in_range ? S_MODIFY : S_DONE;
                end
            end
            S_MODIFY: begin
                // Set or clear one bit of the fetched byte
                ram_we    = 1'b1;
                ram_waddr = AW'(r_cluster[POS_W-1:2]);
                if ((r_op == OP_USED) || (r_op == OP_BAD)) begin
                    ram_wdata = ram_rdata | bit_mask;
                end else begin
                    ram_wdata = ram_rdata & ~bit_mask;
                end
                n_state = S_DONE;
            end
            S_WRITE: begin
                ram_we    = byte_in_range;
                ram_waddr = AW'(r_cluster);
                ram_wdata = r_wbyte;
                n_state   = S_DONE;
            end
            S_SCAN: begin
                // Issue one byte read per cycle, fold the previous one
                if (r_pend) begin
                    n_scan = scan_next;
                end
                if (r_addr < r_scan_len) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr[AW-1:0];
                    n_base    = r_addr[AW-1:0];
                    n_addr    = r_addr + (AW+1)'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // Load the result once the output register is free
                if (!r_out_valid || o_result.ready) begin
                    n_res = '0;
                    case (r_op)
                        OP_FIRST: begin
                            n_res.found    = r_scan.found;
                            n_res.position = r_scan.pos;
                        end
                        OP_RUN: begin
                            n_res.found      = r_scan.found;
                            n_res.position   = r_scan.pos;
                            n_res.run_length = r_scan.len;
                        end
                        OP_STATS: begin
                            n_res.free_count     = r_scan.cnt_free;
                            n_res.used_count     = r_scan.cnt_used;
                            n_res.bad_count      = r_scan.cnt_bad_free + r_scan.cnt_bad_used;
                            n_res.bad_free_count = r_scan.cnt_bad_free;
                            n_res.bad_used_count = r_scan.cnt_bad_used;
                        end
                        OP_READ: begin
                            n_res.read_data = byte_in_range ? ram_rdata : 8'd0;
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_addr          <= '0;
            r_pend          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_cluster_count <= COUNT_W'(4096);
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cluster_count <= i_cfg_data;
            end
        end
    end

    // Item and accumulator registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_cluster  <= n_cluster;
        r_wbyte    <= n_wbyte;
        r_scan_len <= n_scan_len;
        r_base     <= n_base;
        r_scan     <= n_scan;
        r_res      <= n_res;
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.found          = r_res.found;
    assign o_result.position       = r_res.position;
    assign o_result.run_length     = r_res.run_length;
    assign o_result.free_count     = r_res.free_count;
    assign o_result.used_count     = r_res.used_count;
    assign o_result.bad_count      = r_res.bad_count;
    assign o_result.bad_free_count = r_res.bad_free_count;
    assign o_result.bad_used_count = r_res.bad_used_count;
    assign o_result.read_data      = r_res.read_data;
endmodule

// ===== src/cam_checker.sv =====
// Port-level checks for the cluster allocation map and their bind to the
// top level. Depends on cam_pkg and cluster_allocation_map.
module cam_checker
    import cam_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_found,
    input logic [POS_W-1:0]   i_position,
    input logic [COUNT_W-1:0] i_run_length,
    input logic [COUNT_W-1:0] i_bad_count,
    input logic [COUNT_W-1:0] i_bad_free_count,
    input logic [COUNT_W-1:0] i_bad_used_count
);
    // Hold a stalled result: valid, found, position, run length and bad count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_position)
            && $stable(i_found) && $stable(i_run_length) && $stable(i_bad_count))
        else $error("result changed while stalled");

    // Bad clusters split into bad-free and bad-used
    a_bad_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bad_count == COUNT_W'(i_bad_free_count + i_bad_used_count))
        else $error("bad count does not match its parts");

    // Nothing found leaves position and run length zero
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_position == '0 && i_run_length == '0)
        else $error("position or run length set without a find");

    // One item at a time: drop ready after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while busy");
endmodule

bind cluster_allocation_map cam_checker u_cam_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_found          (o_result.found),
    .i_position       (o_result.position),
    .i_run_length     (o_result.run_length),
    .i_bad_count      (o_result.bad_count),
    .i_bad_free_count (o_result.bad_free_count),
    .i_bad_used_count (o_result.bad_used_count)
);
